// ===== hdl/mwrwp_pkg.sv =====
package mwrwp_pkg;

    // Record table geometry and counter width
    localparam int ADDR_BITS  = 16;
    localparam int COUNT_BITS = 16;
    localparam int WORD_BITS  = 16;
    localparam int DEPTH      = 1 << ADDR_BITS;

    // Width used for counter vs. 16-bit comparisons and clamping
    localparam int CMP_BITS = (COUNT_BITS > WORD_BITS) ? COUNT_BITS : WORD_BITS;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LOW     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_HIGH    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUAL_THRESHOLD = 2'd2;

    localparam logic [WORD_BITS-1:0] WINDOW_LOW_RST     = 16'h0000;
    localparam logic [WORD_BITS-1:0] WINDOW_HIGH_RST    = 16'hFFFF;
    localparam logic [WORD_BITS-1:0] QUAL_THRESHOLD_RST = 16'd8;

    // Operation codes
    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [WORD_BITS-1:0]  word_t;

    // One table entry per address
    typedef struct packed {
        logic   seen;
        count_t distinct;
        count_t ups;
        count_t downs;
        count_t outs;
        word_t  first;
        word_t  last;
        word_t  lowest;
        word_t  highest;
    } rec_t;

    localparam int REC_BITS = $bits(rec_t);

    // Controller -> datapath
    typedef struct packed {
        logic clr_step;   // write reset record at sweep address, advance sweep
        logic capture;    // accept input beat, issue table read
        logic update;     // write back observe result
        logic load_out;   // load result register from record
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic clr_last;   // sweep is at the last entry
        logic op_read;    // captured item is a read
    } dp_stat_t;

    function automatic rec_t rec_reset();
        rec_t r;
        r          = '0;
        r.lowest   = '1;
        return r;
    endfunction

    function automatic count_t sat_inc(input count_t c);
        return (c == '1) ? c : count_t'(c + 1'b1);
    endfunction

    function automatic word_t clamp16(input count_t c);
        logic [CMP_BITS-1:0] ext;
        ext = CMP_BITS'(c);
        return (ext > CMP_BITS'(16'hFFFF)) ? 16'hFFFF : ext[WORD_BITS-1:0];
    endfunction

endpackage

// ===== hdl/mwrwp_ram.sv =====
module mwrwp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/mwrwp_ctrl.sv =====
module mwrwp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  mwrwp_pkg::dp_stat_t stat,
    output mwrwp_pkg::dp_cmd_t  cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.op_read)
                begin
                    if (out_free)
                    begin
                        cmd.load_out   = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/mwrwp_dp.sv =====
module mwrwp_dp (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  mwrwp_pkg::dp_cmd_t                       cmd,
    output mwrwp_pkg::dp_stat_t                      stat,
    input  logic                                     cfg_write,
    input  logic [mwrwp_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [mwrwp_pkg::WORD_BITS-1:0]          cfg_data,
    input  logic                                     operation,
    input  logic [15:0]                              address,
    input  logic [15:0]                              word_value,
    output logic [15:0]                              distinct_count,
    output logic [15:0]                              first_value,
    output logic [15:0]                              min_value,
    output logic [15:0]                              max_value,
    output logic [15:0]                              up_count,
    output logic [15:0]                              down_count,
    output logic [15:0]                              out_count,
    output logic                                     qualifies
);

    // Configuration
    mwrwp_pkg::word_t win_lo_reg, win_hi_reg, min_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_lo_reg   <= mwrwp_pkg::WINDOW_LOW_RST;
            win_hi_reg   <= mwrwp_pkg::WINDOW_HIGH_RST;
            min_dist_reg <= mwrwp_pkg::QUAL_THRESHOLD_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mwrwp_pkg::CFG_WINDOW_LOW:     win_lo_reg   <= cfg_data;
                mwrwp_pkg::CFG_WINDOW_HIGH:    win_hi_reg   <= cfg_data;
                mwrwp_pkg::CFG_QUAL_THRESHOLD: min_dist_reg <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // Clearing sweep
    mwrwp_pkg::addr_t clr_addr_reg, clr_addr_next;

    assign clr_addr_next = cmd.clr_step ? mwrwp_pkg::addr_t'(clr_addr_reg + 1'b1)
                                        : clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Captured item
    logic             op_reg;
    mwrwp_pkg::addr_t addr_reg;
    mwrwp_pkg::word_t word_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= operation;
            addr_reg <= mwrwp_pkg::addr_t'(address);
            word_reg <= word_value;
        end
    end

    assign stat.clr_last = (clr_addr_reg == '1);
    assign stat.op_read  = (op_reg == mwrwp_pkg::OP_READ);

    // Record table
    logic                               wr_en;
    mwrwp_pkg::addr_t                   wr_addr;
    logic [mwrwp_pkg::REC_BITS-1:0]     wr_data;
    logic [mwrwp_pkg::REC_BITS-1:0]     rd_data;
    mwrwp_pkg::rec_t                    cur, upd;
    logic                               same, in_win, last_in_win;

    assign cur = mwrwp_pkg::rec_t'(rd_data);

    assign same        = cur.seen && (word_reg == cur.last);
    assign in_win      = (word_reg >= win_lo_reg) && (word_reg <= win_hi_reg);
    assign last_in_win = (cur.last >= win_lo_reg) && (cur.last <= win_hi_reg);

    always_comb
    begin
        upd = cur;
        if (!in_win)
        begin
            upd.outs = mwrwp_pkg::sat_inc(cur.outs);
        end
        else
        begin
            if (cur.distinct == '0)
            begin
                upd.first = word_reg;
            end
            if (cur.seen && last_in_win)
            begin
                if (word_reg > cur.last)
                begin
                    upd.ups = mwrwp_pkg::sat_inc(cur.ups);
                end
                else
                begin
                    upd.downs = mwrwp_pkg::sat_inc(cur.downs);
                end
            end
            upd.distinct = mwrwp_pkg::sat_inc(cur.distinct);
            if (word_reg < cur.lowest)
            begin
                upd.lowest = word_reg;
            end
            if (word_reg > cur.highest)
            begin
                upd.highest = word_reg;
            end
        end
        upd.last = word_reg;
        upd.seen = 1'b1;
    end

    assign wr_en   = cmd.clr_step || (cmd.update && !same);
    assign wr_addr = cmd.clr_step ? clr_addr_reg : addr_reg;
    assign wr_data = cmd.clr_step ? mwrwp_pkg::rec_reset() : upd;

    mwrwp_ram #(
        .WIDTH (mwrwp_pkg::REC_BITS),
        .DEPTH (mwrwp_pkg::DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.capture),
        .rd_addr (mwrwp_pkg::addr_t'(address)),
        .rd_data (rd_data)
    );

    // Result register
    logic [mwrwp_pkg::CMP_BITS-1:0] dist_ext, outs_ext, min_ext;

    assign dist_ext = mwrwp_pkg::CMP_BITS'(cur.distinct);
    assign outs_ext = mwrwp_pkg::CMP_BITS'(cur.outs);
    assign min_ext  = mwrwp_pkg::CMP_BITS'(min_dist_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            distinct_count <= mwrwp_pkg::clamp16(cur.distinct);
            first_value    <= (cur.distinct != '0) ? cur.first : '0;
            min_value      <= cur.lowest;
            max_value      <= cur.highest;
            up_count       <= mwrwp_pkg::clamp16(cur.ups);
            down_count     <= mwrwp_pkg::clamp16(cur.downs);
            out_count      <= mwrwp_pkg::clamp16(cur.outs);
            qualifies      <= (dist_ext >= min_ext) && (outs_ext <= dist_ext);
        end
    end

endmodule

// ===== hdl/memory_word_range_walk_profiler_unit.sv =====
// Per-address word change profiler. Each input beat is either an observe
// (operation 0: the word now seen at an address) or a read (operation 1:
// return that address's record). An observe with the same word as last time
// is ignored; a word outside [window_low, window_high] bumps out_count; an
// in-window word bumps distinct_count, records the first value, tracks
// min/max, and counts up/down steps when the previous word was in-window too.
// Counters saturate and are clamped to 16 bits when reported; qualifies is set
// when distinct_count reaches the qualify threshold (register 2) and
// out_count <= distinct_count.
// Only reads produce an output beat. Each item passes an accept state that
// reads the record table, then an execute state that writes the record back
// or loads the result register; no new item is taken before that, and a read
// waits in the execute state while the output register holds an untaken beat.
// After reset the record table (one 129-bit entry per address, 2^16 entries)
// is swept to its reset value one entry per cycle, with in_stall held high.
// Configuration writes are accepted at any time, including during the sweep,
// but should only be issued while the block is idle.
module memory_word_range_walk_profiler_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_write,
    input  logic [mwrwp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [15:0]                          cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 operation,
    input  logic [15:0]                          address,
    input  logic [15:0]                          word_value,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [15:0]                          distinct_count,
    output logic [15:0]                          first_value,
    output logic [15:0]                          min_value,
    output logic [15:0]                          max_value,
    output logic [15:0]                          up_count,
    output logic [15:0]                          down_count,
    output logic [15:0]                          out_count,
    output logic                                 qualifies
);

    mwrwp_pkg::dp_cmd_t  cmd;
    mwrwp_pkg::dp_stat_t stat;

    // Sequencer: clearing sweep, accept, execute
    mwrwp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Config registers, record table, update logic and result register
    mwrwp_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .operation      (operation),
        .address        (address),
        .word_value     (word_value),
        .distinct_count (distinct_count),
        .first_value    (first_value),
        .min_value      (min_value),
        .max_value      (max_value),
        .up_count       (up_count),
        .down_count     (down_count),
        .out_count      (out_count),
        .qualifies      (qualifies)
    );

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;

    import mwrwp_pkg::*;

    // Timeout: the post-reset sweep plus ~570 beats, each at worst a long
    // gap, the item's own work and a long output stall, come to well under
    // CYCLE_LIMIT.
    localparam int CYCLE_LIMIT   = 2_000_000;
    // Cycles to let an in-flight observe finish before touching registers.
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_BEATS   = 110;

    // Predicted per-address record (counters kept at full COUNT_BITS width).
    typedef struct {
        bit     seen;
        count_t distinct;
        count_t ups;
        count_t downs;
        count_t outs;
        word_t  first;
        word_t  last;
        word_t  lowest;
        word_t  highest;
    } addr_profile_t;

    // What a read beat is expected to return.
    typedef struct {
        logic [15:0] distinct;
        logic [15:0] first;
        logic [15:0] lowest;
        logic [15:0] highest;
        logic [15:0] ups;
        logic [15:0] downs;
        logic [15:0] outs;
        logic        qual;
    } profile_report_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                    cfg_write  = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index  = '0;
    logic [15:0]             cfg_data   = '0;

    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic        operation  = OP_OBSERVE;
    logic [15:0] address    = '0;
    logic [15:0] word_value = '0;

    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [15:0] distinct_count;
    logic [15:0] first_value;
    logic [15:0] min_value;
    logic [15:0] max_value;
    logic [15:0] up_count;
    logic [15:0] down_count;
    logic [15:0] out_count;
    logic        qualifies;

    // Predictor state: register shadows plus a sparse copy of the table.
    // An address missing from profile_table still holds its reset record.
    word_t           win_low       = WINDOW_LOW_RST;
    word_t           win_high      = WINDOW_HIGH_RST;
    word_t           threshold_cfg = QUAL_THRESHOLD_RST;
    addr_profile_t   profile_table [int unsigned];
    profile_report_t report_queue[$];

    int mismatches  = 0;
    int cycle_count = 0;
    int stall_left  = 0;
    int stall_pick  = 0;
    bit send_calm   = 1'b0;   // sender never idles while set
    bit recv_calm   = 1'b0;   // receiver starts no new stall while set

    memory_word_range_walk_profiler_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .address        (address),
        .word_value     (word_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .distinct_count (distinct_count),
        .first_value    (first_value),
        .min_value      (min_value),
        .max_value      (max_value),
        .up_count       (up_count),
        .down_count     (down_count),
        .out_count      (out_count),
        .qualifies      (qualifies)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("memory_word_range_walk_profiler_unit regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Mostly back-to-back, sometimes a short gap, now and then a long hold.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic count_t bump(count_t c);
        return (&c) ? c : count_t'(c + 1'b1);
    endfunction

    // Reported counts are clamped to 16 bits whatever COUNT_BITS is.
    function automatic logic [15:0] report_count(count_t c);
        longint unsigned wide;
        wide = 64'(c);
        return (wide > 64'hFFFF) ? 16'hFFFF : wide[15:0];
    endfunction

    function automatic bit in_window(word_t w);
        return (w >= win_low) && (w <= win_high);
    endfunction

    function automatic addr_profile_t lookup_profile(addr_t a);
        addr_profile_t p;
        if (profile_table.exists(a))
            return profile_table[a];
        p.seen     = 1'b0;
        p.distinct = '0;
        p.ups      = '0;
        p.downs    = '0;
        p.outs     = '0;
        p.first    = '0;
        p.last     = '0;
        p.lowest   = '1;
        p.highest  = '0;
        return p;
    endfunction

    function automatic void observe_word(addr_t a, word_t w);
        addr_profile_t p;
        p = lookup_profile(a);
        // Same word as last time: no change, nothing recorded.
        if (p.seen && w == p.last)
            return;
        if (!in_window(w))
            p.outs = bump(p.outs);
        else
        begin
            if (p.distinct == 0)
                p.first = w;
            // Direction only counts when the previous word was in-window
            // under the window as it stands now.
            if (p.seen && in_window(p.last))
            begin
                if (w > p.last)
                    p.ups = bump(p.ups);
                else
                    p.downs = bump(p.downs);
            end
            p.distinct = bump(p.distinct);
            if (w < p.lowest)
                p.lowest = w;
            if (w > p.highest)
                p.highest = w;
        end
        p.last = w;
        p.seen = 1'b1;
        profile_table[a] = p;
    endfunction

    function automatic profile_report_t predict_report(addr_t a);
        addr_profile_t   p;
        profile_report_t r;
        p          = lookup_profile(a);
        r.distinct = report_count(p.distinct);
        r.first    = (p.distinct != 0) ? p.first : '0;
        r.lowest   = p.lowest;
        r.highest  = p.highest;
        r.ups      = report_count(p.ups);
        r.downs    = report_count(p.downs);
        r.outs     = report_count(p.outs);
        // qualifies works on the unclamped counters
        r.qual     = (p.distinct >= threshold_cfg) && (p.outs <= p.distinct);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------

    task automatic note_failure(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0d] %s", cycle_count, msg);
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
            note_failure($sformatf("%s mismatch: expected %h, got %h", name, want, got));
    endtask

    task automatic check_report();
        profile_report_t want;
        if (report_queue.size() == 0)
        begin
            note_failure("result beat with nothing expected");
            return;
        end
        want = report_queue.pop_front();
        check_field("distinct_count", want.distinct, distinct_count);
        check_field("first_value", want.first, first_value);
        check_field("min_value", want.lowest, min_value);
        check_field("max_value", want.highest, max_value);
        check_field("up_count", want.ups, up_count);
        check_field("down_count", want.downs, down_count);
        check_field("out_count", want.outs, out_count);
        check_field("qualifies", 16'(want.qual), 16'(qualifies));
    endtask

    // Outputs are sampled with their pre-edge values, so a beat counts as
    // taken exactly when the block sees valid high and stall low.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_report();
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (recv_calm)
            out_stall <= 1'b0;
        else
        begin
            stall_pick = pick_gap();
            out_stall  <= (stall_pick != 0);
            stall_left = (stall_pick > 0) ? stall_pick - 1 : 0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Drives one beat and returns at the edge that accepts it. in_valid
    // stays high into the next call when there is no gap, so it never gets
    // two assignments in one step.
    task automatic send_beat(logic op, addr_t addr, word_t word);
        int gap;
        gap = send_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        address    <= addr;
        word_value <= word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == OP_READ)
            report_queue.push_back(predict_report(addr));
        else
            observe_word(addr, word);
    endtask

    // Observes produce nothing, so after the last read returns the block
    // may still be writing back; let it settle for SETTLE_CYCLES.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (report_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, word_t data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_WINDOW_LOW:     win_low = data;
            CFG_WINDOW_HIGH:    win_high = data;
            CFG_QUAL_THRESHOLD: threshold_cfg = data;
            default:            ;
        endcase
    endtask

    task automatic set_window(word_t lo, word_t hi, word_t need);
        write_reg(CFG_WINDOW_LOW, lo);
        write_reg(CFG_WINDOW_HIGH, hi);
        write_reg(CFG_QUAL_THRESHOLD, need);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset window (everything in-window): untouched records, top address,
    // extreme words, repeat suppression, and a first observe of word 0
    // (equal to the reset last word but still counted).
    task automatic test_reset_window_basics();
        send_beat(OP_READ, 16'h1234, 16'h0000);
        send_beat(OP_READ, 16'hFFFF, 16'hFFFF);
        send_beat(OP_OBSERVE, 16'hFFFF, 16'h0000);
        send_beat(OP_OBSERVE, 16'hFFFF, 16'hFFFF);
        send_beat(OP_OBSERVE, 16'hFFFF, 16'hFFFF);
        send_beat(OP_OBSERVE, 16'hFFFF, 16'h8000);
        send_beat(OP_READ, 16'hFFFF, 16'h5555);
        send_beat(OP_OBSERVE, 16'h0000, 16'h0000);
        send_beat(OP_READ, 16'h0000, 16'hAAAA);
    endtask

    // Narrow window: out-only record (first value unset), window edges,
    // re-entry from outside with no direction count, and qualify thresholds.
    task automatic test_window_edges();
        wait_idle();
        set_window(16'h0100, 16'h0200, 16'd3);
        send_beat(OP_OBSERVE, 16'h0042, 16'h00FF);
        send_beat(OP_READ, 16'h0042, 16'h0000);
        send_beat(OP_OBSERVE, 16'h0042, 16'h0100);
        send_beat(OP_OBSERVE, 16'h0042, 16'h0200);
        send_beat(OP_OBSERVE, 16'h0042, 16'h0201);
        send_beat(OP_OBSERVE, 16'h0042, 16'h0100);
        send_beat(OP_OBSERVE, 16'h0042, 16'h0150);
        send_beat(OP_READ, 16'h0042, 16'h0000);
        wait_idle();
        // zero threshold: even an untouched address qualifies
        write_reg(CFG_QUAL_THRESHOLD, 16'h0000);
        send_beat(OP_READ, 16'h7777, 16'h0000);
    endtask

    // low > high: every word lands outside.
    task automatic test_empty_window();
        wait_idle();
        set_window(16'h9000, 16'h8FFF, 16'h0001);
        send_beat(OP_OBSERVE, 16'h0042, 16'h0150);
        send_beat(OP_OBSERVE, 16'h0042, 16'h9000);
        send_beat(OP_READ, 16'h0042, 16'h0000);
    endtask

    // Phases of random traffic, each under its own register setting. Most
    // beats hit a few hot addresses, often with words at or just past the window
    // edges, so that records build up and every branch of the update is taken.
    task automatic test_random_traffic();
        int unsigned hot [8];
        word_t       palette [6];
        int          span;
        int          roll;
        logic        op;
        addr_t       addr;
        word_t       word;
        word_t       lo;
        word_t       hi;
        word_t       need;
        addr_profile_t p;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    lo = 16'h0000;  hi = 16'hFFFF;  need = 16'h0000;
                end
                1:
                begin
                    lo = 16'hFFFF;  hi = 16'h0000;  need = 16'hFFFF;
                end
                2:
                begin
                    lo   = word_t'($urandom_range(0, 16'hFFFF));
                    span = int'(lo) + int'($urandom_range(0, 16'h3000));
                    hi   = (span > 16'hFFFF) ? 16'hFFFF : span[15:0];
                    need = word_t'($urandom_range(1, 6));
                end
                3:
                begin
                    lo = word_t'($urandom_range(0, 16'hFFFF));  hi = lo;  need = 16'h0001;
                end
                default:
                begin
                    lo   = word_t'($urandom_range(0, 16'h8000));
                    hi   = word_t'($urandom_range(16'h8000, 16'hFFFF));
                    need = word_t'($urandom_range(0, 10));
                end
            endcase
            set_window(lo, hi, need);

            hot[0] = 0;
            hot[1] = 32'h0000_FFFF;
            for (int k = 2; k < 8; k++)
                hot[k] = $urandom_range(0, 16'hFFFF);
            palette[0] = win_low;
            palette[1] = win_high;
            palette[2] = win_low - 1'b1;
            palette[3] = win_high + 1'b1;
            palette[4] = word_t'($urandom_range(0, 16'hFFFF));
            palette[5] = word_t'($urandom_range(0, 16'hFFFF));

            for (int i = 0; i < PHASE_BEATS; i++)
            begin
                // stretches where one or both sides run flat out
                if (i % 40 == 0)
                begin
                    send_calm = ($urandom_range(0, 3) == 0);
                    recv_calm = ($urandom_range(0, 3) == 0);
                end
                op   = ($urandom_range(0, 99) < 30) ? OP_READ : OP_OBSERVE;
                addr = ($urandom_range(0, 9) < 7) ? addr_t'(hot[$urandom_range(0, 7)])
                                                  : addr_t'($urandom_range(0, 16'hFFFF));
                roll = $urandom_range(0, 9);
                if (roll < 4)
                    word = palette[$urandom_range(0, 5)];
                else if (roll < 6)
                begin
                    p    = lookup_profile(addr);
                    word = p.last;
                end
                else
                    word = word_t'($urandom_range(0, 16'hFFFF));
                send_beat(op, addr, word);
            end
        end
        send_calm = 1'b0;
        recv_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // The first beat simply waits out the table sweep on in_stall.
        test_reset_window_basics();
        test_window_edges();
        test_empty_window();
        test_random_traffic();
        wait_idle();
        if (mismatches == 0)
            $display("memory_word_range_walk_profiler_unit regression: pass");
        else
            $display("memory_word_range_walk_profiler_unit regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/mwrwp_pkg.sv
hdl/mwrwp_ram.sv
hdl/mwrwp_ctrl.sv
hdl/mwrwp_dp.sv
hdl/memory_word_range_walk_profiler_unit.sv
tb/sv/testbench.sv
